// ===== src/i2c_register_transfer_master_defines.svh =====
// Assertion macros shared by the I2C register transfer master.
`ifndef I2C_REGISTER_TRANSFER_MASTER_DEFINES_SVH
`define I2C_REGISTER_TRANSFER_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define I2CRTM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("i2crtm assertion failed");
// The expression must never be true outside reset.
`define I2CRTM_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("i2crtm forbidden condition seen");
`else
`define I2CRTM_ASSERT(label, clk, rst, prop)
`define I2CRTM_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== src/i2crtm_pkg.sv =====
package i2crtm_pkg;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_BYTE  = 2'd3
   } kind_type;

   // Phase group: the upper bits of the sequencer state.
   typedef enum logic [2:0] {
      GRP_CTRL = 3'd0,
      GRP_ADW  = 3'd1,
      GRP_REG  = 3'd2,
      GRP_ADR  = 3'd3,
      GRP_DAT  = 3'd4,
      GRP_RD   = 3'd5,
      GRP_END  = 3'd6,
      GRP_ERR  = 3'd7
   } grp_type;

   typedef struct packed {
      grp_type    grp;
      logic [2:0] step;
   } phase_type;

   localparam logic [2:0] STEP_FIRST = 3'd0;
   localparam logic [2:0] STEP_WAIT  = 3'd6;
   localparam phase_type PHASE_IDLE = '{grp: GRP_CTRL, step: STEP_FIRST};
   localparam phase_type PHASE_WAIT = '{grp: GRP_DAT, step: STEP_WAIT};

   typedef struct packed {
      kind_type   kind;
      logic [6:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] length;
      logic [7:0] data_byte;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       data_request;
      logic       read_valid;
      logic [7:0] read_data;
      logic       read_last;
      logic       done_res;
      logic       error;
   } result_type;

endpackage

// ===== src/i2c_register_transfer_master.sv =====
// Channel   Direction  Ports                      Payload
// req       in         req_tvalid/tready/tuser    kind in tuser, other fields in tdata
// rsp       out        rsp_tvalid/tready/tdata    pin levels, status, read byte
// csr       in         csr_wr_en/csr_wr_data      ack_timeout
//
// The sequencer steps once per accepted request and its result goes into a single
// output register in the same cycle.
// A new request is taken each cycle while the output register is empty or drained.
// A stalled response holds the register and stops the request side only then.
// Reset is synchronous and returns the bus to idle with both lines released.
`include "i2c_register_transfer_master_defines.svh"

module i2c_register_transfer_master
   import i2crtm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dev_addr[6:0], reg_addr[14:7], length[22:15], data_byte[30:23], sda_in[31]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], data_request[3], read_valid[4],
   // read_data[12:5], read_last[13], done_res[14], error[15]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data
);

   logic [7:0]            timeout_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  accept;
   item_type              item;
   result_type            result;

   assign item.kind      = kind_type'(req_tuser);
   assign item.dev_addr  = req_tdata[6:0];
   assign item.reg_addr  = req_tdata[14:7];
   assign item.length    = req_tdata[22:15];
   assign item.data_byte = req_tdata[30:23];
   assign item.sda_in    = req_tdata[31];

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   i2crtm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .item        (item),
      .ack_timeout (timeout_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= ACK_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {result.error, result.done_res, result.read_last, result.read_data,
                         result.read_valid, result.data_request, result.busy_res,
                         result.sda_out, result.scl_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/i2crtm_core.sv =====
`include "i2c_register_transfer_master_defines.svh"

module i2crtm_core
   import i2crtm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  item_type   item,
   input  logic [7:0] ack_timeout,
   output result_type result
);

   phase_type  phase_ff, phase_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [6:0] slave_ff, slave_in;
   logic [7:0] reg_addr_ff, reg_addr_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] ack_cnt_ff, ack_cnt_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic [2:0] bit_inc;
   logic       last_byte;
   logic       is_tick;

   assign bit_inc   = bit_count_ff + 3'd1;
   assign last_byte = (bytes_left_ff == 8'd1);
   assign is_tick   = (item.kind == KIND_TICK);

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      slave_in      = slave_ff;
      reg_addr_in   = reg_addr_ff;
      is_read_in    = is_read_ff;
      ack_cnt_in    = ack_cnt_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;

      case (item.kind)
         KIND_TICK: begin
            case (phase_ff.grp)
               GRP_CTRL: begin
                  case (phase_ff.step)
                     3'd1: begin scl_in = 1'b1; sda_in = 1'b1; phase_in.step = 3'd2; end
                     3'd2: begin scl_in = 1'b1; sda_in = 1'b0; phase_in.step = 3'd3; end
                     3'd3: begin
                        scl_in = 1'b0; sda_in = 1'b0;
                        shift_in = {slave_ff, 1'b0};
                        bit_count_in = 3'd0;
                        phase_in = '{grp: GRP_ADW, step: STEP_FIRST};
                     end
                     // Repeated start ahead of the read address.
                     3'd4: begin scl_in = 1'b0; sda_in = 1'b1; phase_in.step = 3'd5; end
                     3'd5: begin scl_in = 1'b1; sda_in = 1'b1; phase_in.step = 3'd6; end
                     3'd6: begin scl_in = 1'b1; sda_in = 1'b0; phase_in.step = 3'd7; end
                     3'd7: begin
                        scl_in = 1'b0; sda_in = 1'b0;
                        shift_in = {slave_ff, 1'b1};
                        bit_count_in = 3'd0;
                        phase_in = '{grp: GRP_ADR, step: STEP_FIRST};
                     end
                     default: ;
                  endcase
               end
               GRP_ADW, GRP_REG, GRP_ADR, GRP_DAT: begin
                  case (phase_ff.step)
                     3'd0: begin
                        scl_in = 1'b0; sda_in = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0};
                        phase_in.step = 3'd1;
                     end
                     3'd1: begin scl_in = 1'b1; phase_in.step = 3'd2; end
                     3'd2: begin
                        scl_in = 1'b0;
                        bit_count_in = bit_inc;
                        phase_in.step = (bit_inc != 3'd0) ? 3'd0 : 3'd3;
                     end
                     3'd3: begin scl_in = 1'b0; sda_in = 1'b1; phase_in.step = 3'd4; end
                     3'd4: begin
                        scl_in = 1'b1; sda_in = 1'b1;
                        ack_cnt_in = 8'd0;
                        phase_in.step = 3'd5;
                     end
                     3'd5: begin
                        if (item.sda_in && ack_cnt_ff != ack_timeout) begin
                           ack_cnt_in = ack_cnt_ff + 8'd1;
                        end else if (item.sda_in &&
                                     (phase_ff.grp == GRP_ADW || phase_ff.grp == GRP_DAT)) begin
                           phase_in = '{grp: GRP_ERR, step: STEP_FIRST};
                        end else begin
                           // Acknowledged, or a NACK that this byte ignores.
                           scl_in = 1'b0; sda_in = 1'b1;
                           case (phase_ff.grp)
                              GRP_ADW: begin
                                 shift_in = reg_addr_ff;
                                 bit_count_in = 3'd0;
                                 phase_in = '{grp: GRP_REG, step: STEP_FIRST};
                              end
                              GRP_REG: begin
                                 if (is_read_ff) begin
                                    phase_in = '{grp: GRP_CTRL, step: 3'd4};
                                 end else if (bytes_left_ff != 8'd0) begin
                                    phase_in = PHASE_WAIT;
                                 end else begin
                                    phase_in = '{grp: GRP_END, step: STEP_FIRST};
                                 end
                              end
                              GRP_ADR: begin
                                 bit_count_in = 3'd0;
                                 phase_in = (bytes_left_ff != 8'd0) ?
                                    phase_type'{grp: GRP_RD, step: STEP_FIRST} :
                                    phase_type'{grp: GRP_END, step: STEP_FIRST};
                              end
                              default: begin
                                 bytes_left_in = bytes_left_ff - 8'd1;
                                 phase_in = (bytes_left_ff != 8'd1) ? PHASE_WAIT :
                                    phase_type'{grp: GRP_END, step: STEP_FIRST};
                              end
                           endcase
                        end
                     end
                     default: ;
                  endcase
               end
               GRP_RD: begin
                  case (phase_ff.step)
                     3'd0: begin
                        scl_in = 1'b0; sda_in = 1'b1;
                        bit_count_in = 3'd0;
                        phase_in.step = 3'd1;
                     end
                     3'd1: begin scl_in = 1'b1; sda_in = 1'b1; phase_in.step = 3'd2; end
                     3'd2: begin
                        shift_in = {shift_ff[6:0], item.sda_in};
                        bit_count_in = bit_inc;
                        scl_in = 1'b0; sda_in = 1'b1;
                        phase_in.step = (bit_inc == 3'd0) ? 3'd3 : 3'd1;
                     end
                     // Master ACK, or NACK on the final byte.
                     3'd3: begin scl_in = 1'b0; sda_in = last_byte; phase_in.step = 3'd4; end
                     3'd4: begin scl_in = 1'b1; phase_in.step = 3'd5; end
                     3'd5: begin
                        scl_in = 1'b0; sda_in = 1'b1;
                        bytes_left_in = bytes_left_ff - 8'd1;
                        phase_in = (bytes_left_ff != 8'd1) ?
                           phase_type'{grp: GRP_RD, step: 3'd1} :
                           phase_type'{grp: GRP_END, step: STEP_FIRST};
                     end
                     default: ;
                  endcase
               end
               default: begin
                  // Stop sequence, shared by normal end and abort.
                  case (phase_ff.step)
                     3'd0: begin scl_in = 1'b0; sda_in = 1'b0; phase_in.step = 3'd1; end
                     3'd1: begin scl_in = 1'b1; sda_in = 1'b0; phase_in.step = 3'd2; end
                     default: begin
                        scl_in = 1'b1; sda_in = 1'b1;
                        phase_in = PHASE_IDLE;
                     end
                  endcase
               end
            endcase
         end
         KIND_BYTE: begin
            if (phase_ff == PHASE_WAIT) begin
               shift_in = item.data_byte;
               bit_count_in = 3'd0;
               phase_in = '{grp: GRP_DAT, step: STEP_FIRST};
            end
         end
         default: begin
            if (phase_ff == PHASE_IDLE) begin
               slave_in = item.dev_addr;
               reg_addr_in = item.reg_addr;
               bytes_left_in = item.length;
               is_read_in = (item.kind == KIND_READ);
               phase_in = '{grp: GRP_CTRL, step: 3'd1};
            end
         end
      endcase
   end

   always_comb begin
      result = '0;
      result.scl_out = scl_in;
      result.sda_out = sda_in;
      result.busy_res = (phase_in != PHASE_IDLE);
      result.data_request = (phase_in == PHASE_WAIT);
      result.read_valid = is_tick && phase_ff.grp == GRP_RD && phase_ff.step == 3'd2 &&
                          bit_inc == 3'd0;
      if (result.read_valid) begin
         result.read_data = shift_in;
         result.read_last = last_byte;
      end
      result.done_res = is_tick && (phase_ff.grp == GRP_END || phase_ff.grp == GRP_ERR) &&
                        phase_ff.step >= 3'd2;
      result.error = result.done_res && phase_ff.grp == GRP_ERR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         bytes_left_ff <= '0;
         slave_ff      <= '0;
         reg_addr_ff   <= '0;
         is_read_ff    <= 1'b0;
         ack_cnt_ff    <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         slave_ff      <= slave_in;
         reg_addr_ff   <= reg_addr_in;
         is_read_ff    <= is_read_in;
         ack_cnt_ff    <= ack_cnt_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
      end
   end

   // While a write byte is awaited, SCL must be held low.
   `I2CRTM_ASSERT(a_wait_scl_low, clock, reset, (phase_ff == PHASE_WAIT) |-> !scl_ff)
   // An idle master leaves both lines released.
   `I2CRTM_ASSERT(a_idle_released, clock, reset, (phase_ff == PHASE_IDLE) |-> (scl_ff && sda_ff))
   // A read byte and the stop completion never share one result.
   `I2CRTM_NEVER(a_read_done_clash, clock, reset, result.read_valid && result.done_res)

endmodule

// ===== tb/sv/i2c_register_transfer_master_checker.sv =====
`timescale 1ns / 1ps

module i2c_register_transfer_master_checker
   import i2crtm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // dev_addr[6:0], reg_addr[14:7], length[22:15], data_byte[30:23], sda_in[31]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], data_request[3], read_valid[4],
   // read_data[12:5], read_last[13], done_res[14], error[15]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   output int                    failures,
   output int                    outstanding
);

   result_type bus_reports[$];

   // Shadow copy of the sequencer.
   logic [7:0] ack_limit = ACK_TIMEOUT_RESET;
   phase_type  phase = PHASE_IDLE;
   logic [2:0] bit_cnt = '0;
   logic [7:0] shift_reg = '0;
   logic [7:0] bytes_left = '0;
   logic [6:0] device_addr = '0;
   logic [7:0] reg_addr = '0;
   logic       is_read = 1'b0;
   logic [7:0] ack_wait = '0;
   logic       scl_lvl = 1'b1;
   logic       sda_lvl = 1'b1;

   function automatic phase_type ph(input grp_type g, input logic [2:0] s);
      ph = '{grp: g, step: s};
   endfunction

   task automatic drive_pins(input logic scl, input logic sda);
      scl_lvl = scl;
      sda_lvl = sda;
   endtask

   task automatic load_byte(input grp_type g, input logic [7:0] b);
      shift_reg = b;
      bit_cnt = 3'd0;
      phase = ph(g, STEP_FIRST);
   endtask

   task automatic advance_sequencer(input item_type it, output result_type r);
      logic held_sda;
      logic last_byte;
      r = '0;
      held_sda = sda_lvl;
      last_byte = (bytes_left == 8'd1);
      case (it.kind)
         KIND_TICK: begin
            case (phase.grp)
               GRP_CTRL: begin
                  case (phase.step)
                     3'd1: begin drive_pins(1'b1, 1'b1); phase.step = 3'd2; end
                     3'd2: begin drive_pins(1'b1, 1'b0); phase.step = 3'd3; end
                     3'd3: begin
                        drive_pins(1'b0, 1'b0);
                        load_byte(GRP_ADW, {device_addr, 1'b0});
                     end
                     // Repeated start before the read address.
                     3'd4: begin drive_pins(1'b0, 1'b1); phase.step = 3'd5; end
                     3'd5: begin drive_pins(1'b1, 1'b1); phase.step = 3'd6; end
                     3'd6: begin drive_pins(1'b1, 1'b0); phase.step = 3'd7; end
                     3'd7: begin
                        drive_pins(1'b0, 1'b0);
                        load_byte(GRP_ADR, {device_addr, 1'b1});
                     end
                     default: ;
                  endcase
               end
               GRP_ADW, GRP_REG, GRP_ADR, GRP_DAT: begin
                  case (phase.step)
                     3'd0: begin
                        drive_pins(1'b0, shift_reg[7]);
                        shift_reg = shift_reg << 1;
                        phase.step = 3'd1;
                     end
                     3'd1: begin drive_pins(1'b1, held_sda); phase.step = 3'd2; end
                     3'd2: begin
                        drive_pins(1'b0, held_sda);
                        bit_cnt = bit_cnt + 3'd1;
                        phase.step = (bit_cnt != 3'd0) ? 3'd0 : 3'd3;
                     end
                     3'd3: begin drive_pins(1'b0, 1'b1); phase.step = 3'd4; end
                     3'd4: begin
                        drive_pins(1'b1, 1'b1);
                        ack_wait = '0;
                        phase.step = 3'd5;
                     end
                     3'd5: begin
                        if (it.sda_in && ack_wait != ack_limit) begin
                           ack_wait = ack_wait + 8'd1;
                        end else if (it.sda_in &&
                                     (phase.grp == GRP_ADW || phase.grp == GRP_DAT)) begin
                           phase = ph(GRP_ERR, STEP_FIRST);
                        end else begin
                           // Acknowledged, or a NACK that this byte ignores.
                           drive_pins(1'b0, 1'b1);
                           case (phase.grp)
                              GRP_ADW: load_byte(GRP_REG, reg_addr);
                              GRP_REG: begin
                                 if (is_read) phase = ph(GRP_CTRL, 3'd4);
                                 else if (bytes_left != 8'd0) phase = PHASE_WAIT;
                                 else phase = ph(GRP_END, STEP_FIRST);
                              end
                              GRP_ADR: begin
                                 bit_cnt = 3'd0;
                                 phase = (bytes_left != 8'd0) ? ph(GRP_RD, STEP_FIRST)
                                                              : ph(GRP_END, STEP_FIRST);
                              end
                              default: begin
                                 bytes_left = bytes_left - 8'd1;
                                 phase = (bytes_left != 8'd0) ? PHASE_WAIT
                                                              : ph(GRP_END, STEP_FIRST);
                              end
                           endcase
                        end
                     end
                     default: ;
                  endcase
               end
               GRP_RD: begin
                  case (phase.step)
                     3'd0: begin
                        drive_pins(1'b0, 1'b1);
                        bit_cnt = 3'd0;
                        phase.step = 3'd1;
                     end
                     3'd1: begin drive_pins(1'b1, 1'b1); phase.step = 3'd2; end
                     3'd2: begin
                        shift_reg = {shift_reg[6:0], it.sda_in};
                        bit_cnt = bit_cnt + 3'd1;
                        drive_pins(1'b0, 1'b1);
                        if (bit_cnt == 3'd0) begin
                           r.read_valid = 1'b1;
                           r.read_data = shift_reg;
                           r.read_last = last_byte;
                           phase.step = 3'd3;
                        end else begin
                           phase.step = 3'd1;
                        end
                     end
                     // The master answers ACK, or NACK on the final byte.
                     3'd3: begin drive_pins(1'b0, last_byte); phase.step = 3'd4; end
                     3'd4: begin drive_pins(1'b1, held_sda); phase.step = 3'd5; end
                     3'd5: begin
                        drive_pins(1'b0, 1'b1);
                        bytes_left = bytes_left - 8'd1;
                        phase = (bytes_left != 8'd0) ? ph(GRP_RD, 3'd1)
                                                     : ph(GRP_END, STEP_FIRST);
                     end
                     default: ;
                  endcase
               end
               default: begin
                  case (phase.step)
                     3'd0: begin drive_pins(1'b0, 1'b0); phase.step = 3'd1; end
                     3'd1: begin drive_pins(1'b1, 1'b0); phase.step = 3'd2; end
                     default: begin
                        drive_pins(1'b1, 1'b1);
                        r.done_res = 1'b1;
                        r.error = (phase.grp == GRP_ERR);
                        phase = PHASE_IDLE;
                     end
                  endcase
               end
            endcase
         end
         KIND_BYTE: begin
            if (phase == PHASE_WAIT) load_byte(GRP_DAT, it.data_byte);
         end
         default: begin
            if (phase == PHASE_IDLE) begin
               device_addr = it.dev_addr;
               reg_addr = it.reg_addr;
               bytes_left = it.length;
               is_read = (it.kind == KIND_READ);
               phase = ph(GRP_CTRL, 3'd1);
            end
         end
      endcase
      r.scl_out = scl_lvl;
      r.sda_out = sda_lvl;
      r.busy_res = (phase != PHASE_IDLE);
      r.data_request = (phase == PHASE_WAIT);
   endtask

   task automatic compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
         failures = failures + 1;
      end
   endtask

   always @(posedge clock) begin : watch
      item_type   beat;
      result_type want;
      result_type seen;
      if (reset) begin
         bus_reports.delete();
         ack_limit = ACK_TIMEOUT_RESET;
         phase = PHASE_IDLE;
         bit_cnt = '0;
         shift_reg = '0;
         bytes_left = '0;
         device_addr = '0;
         reg_addr = '0;
         is_read = 1'b0;
         ack_wait = '0;
         drive_pins(1'b1, 1'b1);
      end else begin
         if (csr_wr_en) ack_limit = csr_wr_data;
         if (req_tvalid && req_tready) begin
            beat.kind = kind_type'(req_tuser);
            beat.dev_addr = req_tdata[6:0];
            beat.reg_addr = req_tdata[14:7];
            beat.length = req_tdata[22:15];
            beat.data_byte = req_tdata[30:23];
            beat.sda_in = req_tdata[31];
            advance_sequencer(beat, want);
            bus_reports.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (bus_reports.size() == 0) begin
               $error("response beat arrived with no prediction pending");
               failures = failures + 1;
            end else begin
               want = bus_reports.pop_front();
               seen.scl_out = rsp_tdata[0];
               seen.sda_out = rsp_tdata[1];
               seen.busy_res = rsp_tdata[2];
               seen.data_request = rsp_tdata[3];
               seen.read_valid = rsp_tdata[4];
               seen.read_data = rsp_tdata[12:5];
               seen.read_last = rsp_tdata[13];
               seen.done_res = rsp_tdata[14];
               seen.error = rsp_tdata[15];
               compare_field("scl_out", int'(want.scl_out), int'(seen.scl_out));
               compare_field("sda_out", int'(want.sda_out), int'(seen.sda_out));
               compare_field("busy_res", int'(want.busy_res), int'(seen.busy_res));
               compare_field("data_request", int'(want.data_request),
                             int'(seen.data_request));
               compare_field("read_valid", int'(want.read_valid), int'(seen.read_valid));
               compare_field("read_data", int'(want.read_data), int'(seen.read_data));
               compare_field("read_last", int'(want.read_last), int'(seen.read_last));
               compare_field("done_res", int'(want.done_res), int'(seen.done_res));
               compare_field("error", int'(want.error), int'(seen.error));
            end
         end
      end
      outstanding = bus_reports.size();
   end

endmodule

// ===== tb/sv/i2c_register_transfer_master_test.sv =====
`timescale 1ns / 1ps

module i2c_register_transfer_master_test;
   import i2crtm_pkg::*;

   localparam int RSP_BUSY = 2;
   localparam int RSP_DATA_REQUEST = 3;
   localparam int RSP_DONE = 14;
   localparam int ITEM_TARGET = 450;
   localparam int STEADY_FROM = 250;
   localparam int STEADY_UNTIL = 370;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = KIND_TICK;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [7:0]            csr_wr_data = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   int                    failures;
   int                    outstanding;

   logic req_taken = 1'b0;
   logic want_byte = 1'b0;
   logic bus_busy = 1'b0;
   logic steady = 1'b0;
   int   stops_seen = 0;
   int   items_sent = 0;

   i2c_register_transfer_master uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   i2c_register_transfer_master_checker bus_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 23);
   end

   // Handshakes and bus status as seen at the rising edge, read back at the falling edge.
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (rsp_tvalid && rsp_tready) begin
         want_byte <= rsp_tdata[RSP_DATA_REQUEST];
         bus_busy <= rsp_tdata[RSP_BUSY];
         if (rsp_tdata[RSP_DONE]) stops_seen <= stops_seen + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken,
   // leaving tvalid high so that a following beat can go out without a gap.
   task automatic send_item(input kind_type k, input logic [6:0] dev, input logic [7:0] ra,
                            input logic [7:0] len, input logic [7:0] db, input logic sda);
      while (!steady && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= {sda, db, len, ra, dev};
      do @(negedge clock); while (!req_taken);
      items_sent++;
   endtask

   // Drains every response and ticks the bus, or feeds a byte when one is requested, until the master reports idle.
   task automatic settle_bus();
      forever begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while (outstanding != 0) @(negedge clock);
         repeat (2) @(negedge clock);
         if (!bus_busy) break;
         if (want_byte)
            send_item(KIND_BYTE, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
         else
            send_item(KIND_TICK, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
      end
   endtask

   task automatic write_timeout(input logic [7:0] value);
      settle_bus();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // high_pct sets how often the slave leaves SDA high, which decides ACK versus
   // NACK and the value of read bits. With shove set, a second start and an
   // unrequested byte follow the start and must both be ignored.
   task automatic run_transfer(input kind_type k, input logic [6:0] dev, input logic [7:0] ra,
                               input logic [7:0] len, input int high_pct, input bit shove);
      int stops_before;
      stops_before = stops_seen;
      send_item(k, dev, ra, len, 8'($urandom), 1'($urandom));
      if (shove) begin
         send_item((k == KIND_WRITE) ? KIND_READ : KIND_WRITE,
                   7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
         send_item(KIND_BYTE, 7'($urandom), 8'($urandom), 8'($urandom), 8'hA5,
                   1'($urandom));
      end
      while (stops_seen == stops_before) begin
         if (want_byte && $urandom_range(3) != 0)
            send_item(KIND_BYTE, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
         else if ($urandom_range(49) == 0)
            send_item(kind_type'($urandom_range(3, 1)),
                      7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'($urandom));
         else
            send_item(KIND_TICK, 7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      $urandom_range(99) < high_pct);
      end
   endtask

   initial begin
      int         high_pct;
      logic [7:0] len;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Idle master: ticks and a stray byte change nothing.
      send_item(KIND_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_item(KIND_TICK, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_item(KIND_BYTE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      // Shortest timeout: the address byte is refused and the write aborts.
      write_timeout(8'd0);
      run_transfer(KIND_WRITE, 7'h7F, 8'hFF, 8'hFF, 100, 1'b1);
      write_timeout(8'd255);
      run_transfer(KIND_READ, 7'h00, 8'h00, 8'h00, 0, 1'b0);
      run_transfer(KIND_WRITE, 7'h2A, 8'h55, 8'h00, 0, 1'b0);

      while (items_sent < ITEM_TARGET) begin
         steady <= (items_sent >= STEADY_FROM) && (items_sent < STEADY_UNTIL);
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(4))
               0: write_timeout(8'd0);
               1: write_timeout(8'($urandom_range(4, 1)));
               2: write_timeout(ACK_TIMEOUT_RESET);
               3: write_timeout(8'd255);
               default: write_timeout(8'($urandom_range(255)));
            endcase
         end
         case ($urandom_range(9))
            0, 1, 2, 3, 4: high_pct = 10;
            5, 6: high_pct = 50;
            7: high_pct = 0;
            8: high_pct = 90;
            default: high_pct = 100;
         endcase
         if ($urandom_range(99) < 60) len = 8'($urandom_range(3));
         else len = 8'($urandom_range(8, 4));
         run_transfer($urandom_range(1) ? KIND_READ : KIND_WRITE,
                      7'($urandom), 8'($urandom), len, high_pct, $urandom_range(9) == 0);
      end
      steady <= 1'b0;

      settle_bus();
      repeat (5) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/i2crtm_pkg.sv
src/i2crtm_core.sv
src/i2c_register_transfer_master.sv
tb/sv/i2c_register_transfer_master_checker.sv
tb/sv/i2c_register_transfer_master_test.sv
